// File: rtl/elfdt_pkg.sv
// Shared types, codes and sizes of the dynamic table parser
package elfdt_pkg;

  // entry layout: signed tag word then value word, little-endian
  localparam int EntryBytes = 16;
  localparam int EntryShift = $clog2(EntryBytes);
  localparam int PosW       = EntryShift;
  localparam int AccW       = EntryBytes * 8;
  localparam int WordW      = 64;
  localparam int IdxW       = 60;
  localparam int TypeW      = 32;

  // configuration port
  localparam int CfgAddrW   = 5;
  localparam int CfgDataW   = 64;

  // result queue depth default
  localparam int ResDepth   = 4;

  // dynamic segment program header type
  localparam logic [TypeW-1:0] PtDynamic = TypeW'(2);

  typedef enum logic [1:0] {
    REG_SEG_TYPE   = 2'd0,
    REG_SEG_OFFSET = 2'd1,
    REG_SEG_SIZE   = 2'd2,
    REG_FILE_LEN   = 2'd3
  } reg_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_DYN  = 3'd1,
    ERR_NO_TERM  = 3'd2,
    ERR_BAD_SIZE = 3'd3,
    ERR_OVERFLOW = 3'd4,
    ERR_BOUNDS   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STREAM = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // segment header registers
  typedef struct packed {
    logic [TypeW-1:0] segment_type;
    logic [WordW-1:0] segment_offset;
    logic [WordW-1:0] segment_size;
    logic [WordW-1:0] file_len;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_e                   kind;
    logic signed [WordW-1:0] tag;
    logic [WordW-1:0]        entry_value;
    logic [IdxW-1:0]         entry_pos;
    err_e                    error_code;
    logic [WordW-1:0]        error_offset;
    logic                    last;
  } result_t;

endpackage

// File: rtl/elfdt_cfg_regs.sv
// Configuration register file behind the APB-style port
module elfdt_cfg_regs import elfdt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  // registers sit at 8-byte strides
  assign sel    = reg_e'(paddr[CfgAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_SEG_TYPE:   cfg_d.segment_type   = pwdata[TypeW-1:0];
        REG_SEG_OFFSET: cfg_d.segment_offset = pwdata;
        REG_SEG_SIZE:   cfg_d.segment_size   = pwdata;
        REG_FILE_LEN:   cfg_d.file_len       = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    case (sel)
      REG_SEG_TYPE:   prdata = {{(CfgDataW-TypeW){1'b0}}, cfg_q.segment_type};
      REG_SEG_OFFSET: prdata = cfg_q.segment_offset;
      REG_SEG_SIZE:   prdata = cfg_q.segment_size;
      REG_FILE_LEN:   prdata = cfg_q.file_len;
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/elfdt_hdr_check.sv
// Segment header validation in priority order
module elfdt_hdr_check import elfdt_pkg::*; (
  input  cfg_t cfg_i,
  output err_e err_o
);

  logic [WordW:0] end_sum;
  logic           bad_type;
  logic           zero_size;
  logic           odd_size;
  logic           overflow;
  logic           out_bounds;

  assign end_sum    = {1'b0, cfg_i.segment_offset} + {1'b0, cfg_i.segment_size};
  assign bad_type   = cfg_i.segment_type != PtDynamic;
  assign zero_size  = cfg_i.segment_size == '0;
  assign odd_size   = |cfg_i.segment_size[EntryShift-1:0];
  assign overflow   = end_sum[WordW];
  assign out_bounds = (cfg_i.segment_offset > cfg_i.file_len) ||
                      (end_sum[WordW-1:0] > cfg_i.file_len);

  // first failing check wins
  always_comb begin
    if (bad_type) begin
      err_o = ERR_NOT_DYN;
    end else if (zero_size) begin
      err_o = ERR_NO_TERM;
    end else if (odd_size) begin
      err_o = ERR_BAD_SIZE;
    end else if (overflow) begin
      err_o = ERR_OVERFLOW;
    end else if (out_bounds) begin
      err_o = ERR_BOUNDS;
    end else begin
      err_o = ERR_NONE;
    end
  end

endmodule

// File: rtl/elfdt_core.sv
// Parse state, byte assembly and result generation
module elfdt_core import elfdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  input  err_e       hdr_err_i,
  output logic [1:0] push_cnt_o,
  output result_t    res0_o,
  output result_t    res1_o
);

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [AccW-1:0]  word;
  logic [IdxW-1:0]  tbl_entries;
  logic [IdxW:0]    idx_plus;
  logic             end_tag;
  logic             exhausted;
  op_e              op;

  assign op          = op_e'(opcode_i);
  // bytes shift in from the top, so the first byte lands in bits 7:0
  assign word        = {data_byte_i, acc_q[AccW-1:8]};
  assign tbl_entries = cfg_i.segment_size[WordW-1:EntryShift];
  assign idx_plus    = {1'b0, cnt_q} + {{IdxW{1'b0}}, 1'b1};
  assign exhausted   = idx_plus >= {1'b0, tbl_entries};
  assign end_tag     = word[WordW-1:0] == '0;

  // next state and results
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    push_cnt_o = 2'd0;
    res0_o     = '0;
    res1_o     = '0;
    if (accept_i) begin
      case (op)
        OP_START: begin
          pos_d = '0;
          cnt_d = '0;
          if (hdr_err_i != ERR_NONE) begin
            phase_d             = PH_DONE;
            push_cnt_o          = 2'd1;
            res0_o.kind         = KIND_ERROR;
            res0_o.error_code   = hdr_err_i;
            res0_o.error_offset = cfg_i.segment_offset;
            res0_o.last         = 1'b1;
          end else begin
            phase_d = PH_STREAM;
          end
        end
        OP_DATA: begin
          if (phase_q == PH_STREAM) begin
            acc_d = word;
            if (pos_q != PosW'(EntryBytes - 1)) begin
              pos_d = pos_q + 1'b1;
            end else begin
              // entry complete
              pos_d              = '0;
              cnt_d              = cnt_q + 1'b1;
              push_cnt_o         = 2'd1;
              res0_o.kind        = KIND_ENTRY;
              res0_o.tag         = word[WordW-1:0];
              res0_o.entry_value = word[AccW-1:WordW];
              res0_o.entry_pos   = cnt_q;
              res0_o.last        = end_tag;
              if (end_tag) begin
                phase_d = PH_DONE;
              end else if (exhausted) begin
                // segment used up with no terminator
                phase_d             = PH_DONE;
                push_cnt_o          = 2'd2;
                res1_o.kind         = KIND_ERROR;
                res1_o.entry_pos    = tbl_entries;
                res1_o.error_code   = ERR_NO_TERM;
                res1_o.error_offset = cfg_i.segment_offset;
                res1_o.last         = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers and byte accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // two results only come from a finished entry while streaming
  a_two_only_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_o == 2'd2) |-> (phase_q == PH_STREAM && op == OP_DATA))
    else $error("double result outside streaming");

  // a partial entry exists only while streaming
  a_pos_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> (phase_q == PH_STREAM))
    else $error("byte position set outside streaming");

  // a failed header check leaves the parse done
  a_hdr_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && op == OP_START && hdr_err_i != ERR_NONE) |=> (phase_q == PH_DONE))
    else $error("header error did not end the parse");

endmodule

// File: rtl/elfdt_res_fifo.sv
// Result queue taking up to two items per cycle and giving one while the output is not stalled
module elfdt_res_fifo import elfdt_pkg::*; #(
  parameter int Depth = ResDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_ptr_nx   = ptr_next(wr_ptr_q);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  // room for two more items is required before taking an input item
  assign full_o      = cnt_q > CntW'(Depth - 2);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    case (push_cnt_i)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_next(wr_ptr_nx);
      default: ;
    endcase
    if (pop) begin
      rd_ptr_d = ptr_next(rd_ptr_q);
    end
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  // never more items than slots
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (cnt_q <= CntW'(Depth - 2) || pop))
    else $error("result queue overflow");

  // the count follows pushes and pops
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (cnt_q == $past(cnt_q) + CntW'($past(push_cnt_i)) - CntW'($past(pop))))
    else $error("result count out of step");

endmodule

// File: rtl/elf_dynamic_table_parser_unit.sv
// Top level of the ELF64 dynamic table parser
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   in_opcode_i, in_data_byte_i
//  out      output     out_valid_o/out_stall_i kind, tag, value, index, error, offset, last
//  cfg      input      psel/penable/pwrite     paddr, pwdata, prdata (64 bit, 8-byte stride)
//
// One input item is taken per cycle unless stalled; its results enter the result queue
// at the same edge; the first shows on the outputs the next cycle if the queue was empty.
// A finished entry with no terminator left gives two results, an entry and an error.
// in_stall_o rises when the result queue has fewer than two free slots.
// Reset clears the parse state, queue pointers and all configuration registers.
module elf_dynamic_table_parser_unit import elfdt_pkg::*; #(
  parameter int ResQueueDepth = ResDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_opcode_i,
  input  logic [7:0]              in_data_byte_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    out_kind_o,
  output logic signed [WordW-1:0] out_tag_o,
  output logic [WordW-1:0]        out_entry_value_o,
  output logic [IdxW-1:0]         out_entry_pos_o,
  output logic [2:0]              out_error_code_o,
  output logic [WordW-1:0]        out_error_offset_o,
  output logic                    out_last_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrW-1:0]     paddr,
  input  logic [CfgDataW-1:0]     pwdata,
  output logic [CfgDataW-1:0]     prdata,
  output logic                    pready
);

  cfg_t       cfg;
  err_e       hdr_err;
  logic [1:0] push_cnt;
  result_t    res0, res1, head;
  logic       accept;

  assign accept = in_valid_i && !in_stall_o;

  elfdt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  elfdt_hdr_check u_hdr (
    .cfg_i (cfg),
    .err_o (hdr_err)
  );

  elfdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (in_opcode_i),
    .data_byte_i (in_data_byte_i),
    .cfg_i       (cfg),
    .hdr_err_i   (hdr_err),
    .push_cnt_o  (push_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  elfdt_res_fifo #(
    .Depth (ResQueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // result fields
  assign out_kind_o         = head.kind;
  assign out_tag_o          = head.tag;
  assign out_entry_value_o  = head.entry_value;
  assign out_entry_pos_o    = head.entry_pos;
  assign out_error_code_o   = head.error_code;
  assign out_error_offset_o = head.error_offset;
  assign out_last_o         = head.last;

endmodule

// File: sim/tb_elf_dynamic_table_parser_unit.sv
// Self-checking testbench of the ELF64 dynamic table parser: header checks, entry decode, stalls
`timescale 1ns / 100ps

module tb_elf_dynamic_table_parser_unit;
  import elfdt_pkg::*;

  // receiver hold-off length, and quiet cycles before the run is declared hung;
  // the slowest correct stretch is the hold-off plus a few idle bursts
  localparam int unsigned StallHold   = 300;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned DrainCycles = 4;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic                    in_opcode_i    = 1'b0;
  logic [7:0]              in_data_byte_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic                    out_kind_o;
  logic signed [WordW-1:0] out_tag_o;
  logic [WordW-1:0]        out_entry_value_o;
  logic [IdxW-1:0]         out_entry_pos_o;
  logic [2:0]              out_error_code_o;
  logic [WordW-1:0]        out_error_offset_o;
  logic                    out_last_o;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [CfgAddrW-1:0]     paddr          = '0;
  logic [CfgDataW-1:0]     pwdata         = '0;
  logic [CfgDataW-1:0]     prdata;
  logic                    pready;

  elf_dynamic_table_parser_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_data_byte_i     (in_data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_kind_o         (out_kind_o),
    .out_tag_o          (out_tag_o),
    .out_entry_value_o  (out_entry_value_o),
    .out_entry_pos_o    (out_entry_pos_o),
    .out_error_code_o   (out_error_code_o),
    .out_error_offset_o (out_error_offset_o),
    .out_last_o         (out_last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the header registers and the parse state
  cfg_t             hdr_cfg   = '0;
  phase_e           parse_phase = PH_IDLE;
  logic [3:0]       byte_pos  = '0;
  logic [WordW-1:0] tag_acc   = '0;
  logic [WordW-1:0] val_acc   = '0;
  logic [IdxW-1:0]  entry_cnt = '0;

  // decoded entries and error reports still to come out of the block
  result_t reports_due[$];

  int unsigned fail_count   = 0;
  int unsigned fed_items    = 0;
  int unsigned hold_left    = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on    = 1'b1;

  // queue an error report; any error ends the parse
  function automatic void push_error(err_e code, logic [IdxW-1:0] idx);
    result_t r;
    r              = '0;
    r.kind         = KIND_ERROR;
    r.entry_pos    = idx;
    r.error_code   = code;
    r.error_offset = hdr_cfg.segment_offset;
    r.last         = 1'b1;
    reports_due    = {reports_due, r};
    parse_phase = PH_DONE;
  endfunction

  // advance the parse by one accepted item; returns 0 when the item is ignored
  function automatic bit parse_step(op_e op, logic [7:0] b);
    result_t          r;
    logic [WordW-1:0] table_len;
    if (op == OP_START) begin
      byte_pos  = '0;
      tag_acc   = '0;
      val_acc   = '0;
      entry_cnt = '0;
      if (hdr_cfg.segment_type != PtDynamic) begin
        push_error(ERR_NOT_DYN, '0);
      end else if (hdr_cfg.segment_size == '0) begin
        push_error(ERR_NO_TERM, '0);
      end else if (hdr_cfg.segment_size[EntryShift-1:0] != '0) begin
        push_error(ERR_BAD_SIZE, '0);
      end else if (hdr_cfg.segment_offset > ~hdr_cfg.segment_size) begin
        push_error(ERR_OVERFLOW, '0);
      end else if (hdr_cfg.segment_offset > hdr_cfg.file_len ||
                   hdr_cfg.segment_offset + hdr_cfg.segment_size > hdr_cfg.file_len) begin
        push_error(ERR_BOUNDS, '0);
      end else begin
        parse_phase = PH_STREAM;
      end
      return 1'b1;
    end
    if (parse_phase != PH_STREAM) return 1'b0;

    // little-endian shift into tag word, then value word
    if (!byte_pos[3]) tag_acc[{byte_pos[2:0], 3'b000} +: 8] = b;
    else val_acc[{byte_pos[2:0], 3'b000} +: 8] = b;
    if (byte_pos != 4'd15) begin
      byte_pos++;
      return 1'b1;
    end

    // entry complete
    table_len     = hdr_cfg.segment_size >> EntryShift;
    r             = '0;
    r.kind        = KIND_ENTRY;
    r.tag         = tag_acc;
    r.entry_value = val_acc;
    r.entry_pos   = entry_cnt;
    r.error_code  = ERR_NONE;
    r.last        = (tag_acc == '0);
    reports_due   = {reports_due, r};
    if (r.last) parse_phase = PH_DONE;
    else if ({4'b0, entry_cnt} + 64'd1 >= table_len) push_error(ERR_NO_TERM, table_len[IdxW-1:0]);
    entry_cnt = entry_cnt + 1'b1;
    byte_pos  = '0;
    tag_acc   = '0;
    val_acc   = '0;
    return 1'b1;
  endfunction

  // tags weighted toward terminators, small and negative values
  function automatic logic [WordW-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WordW'($urandom_range(1, 40));
      2:       return {1'b1, 31'($urandom), 32'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // send one item, with an occasional idle burst before it
  task automatic send_item(op_e op, logic [7:0] b);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    in_opcode_i    <= op;
    in_data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    void'(parse_step(op, b));
    fed_items++;
  endtask

  // stream the first nbytes of one 16-byte entry
  task automatic send_entry(logic [WordW-1:0] tag, logic [WordW-1:0] value, int unsigned nbytes);
    logic [AccW-1:0] raw;
    raw = {value, tag};
    for (int i = 0; i < nbytes; i++) send_item(OP_DATA, raw[8*i +: 8]);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SEG_TYPE:   hdr_cfg.segment_type   = value[TypeW-1:0];
      REG_SEG_OFFSET: hdr_cfg.segment_offset = value;
      REG_SEG_SIZE:   hdr_cfg.segment_size   = value;
      REG_FILE_LEN:   hdr_cfg.file_len       = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_header(logic [TypeW-1:0] seg_type, logic [WordW-1:0] offset,
                            logic [WordW-1:0] size, logic [WordW-1:0] fsize);
    drain_results();
    write_reg(REG_SEG_TYPE, CfgDataW'(seg_type));
    write_reg(REG_SEG_OFFSET, offset);
    write_reg(REG_SEG_SIZE, size);
    write_reg(REG_FILE_LEN, fsize);
  endtask

  // every header check in order, plus bytes ignored while idle and done
  task automatic test_header_checks();
    send_item(OP_DATA, 8'hA5);
    send_item(OP_START, 8'h00);
    set_header('1, '1, 64'h10, '0);
    send_item(OP_START, 8'hFF);
    set_header(PtDynamic, '0, '0, '1);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'hFF);
    set_header(PtDynamic, '0, 64'h8, '1);
    send_item(OP_START, 8'h00);
    set_header(PtDynamic, '0, '1, '1);
    send_item(OP_START, 8'h00);
    set_header(PtDynamic, '1, 64'h10, '1);
    send_item(OP_START, 8'h00);
    set_header(PtDynamic, 64'h100, 64'h10, 64'h80);
    send_item(OP_START, 8'h00);
    set_header(PtDynamic, 64'h100, 64'h10, 64'h10F);
    send_item(OP_START, 8'h00);
  endtask

  // restart mid-entry, extreme tags and values, size change mid-parse, terminator
  task automatic test_entry_decode();
    set_header(PtDynamic, 64'h100, 64'h20, 64'h120);
    send_item(OP_START, 8'h00);
    send_entry(64'h1122_3344_5566_7788, '0, 3);
    send_item(OP_START, 8'h00);
    send_entry(64'h7FFF_FFFF_FFFF_FFFF, '0, 16);
    drain_results();
    // shrink the table during the parse: the next entry exhausts it
    write_reg(REG_SEG_SIZE, 64'h10);
    send_entry(64'h8000_0000_0000_0000, '1, 16);
    send_item(OP_DATA, 8'h5A);
    set_header(PtDynamic, '0, 64'h30, 64'h30);
    send_item(OP_START, 8'h00);
    send_entry('0, 64'hDEAD_BEEF_0123_4567, 16);
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    set_header(PtDynamic, '0, 64'h80, 64'h80);
    send_item(OP_START, 8'h00);
    hold_left = StallHold;
    repeat (6) send_entry({$urandom, $urandom} | 64'd1, {$urandom, $urandom}, 16);
    drain_results();
  endtask

  // one header setting, mostly good, sometimes extreme or broken
  task automatic pick_header();
    logic [TypeW-1:0] seg_type;
    logic [WordW-1:0] offset;
    logic [WordW-1:0] size;
    logic [WordW-1:0] fsize;
    seg_type = PtDynamic;
    size     = WordW'(16 * $urandom_range(1, 6));
    offset   = {$urandom, $urandom} >> $urandom_range(0, 63);
    if (offset > 64'hFFFF_FFFF_FFFF_FF00) offset = 64'hFFFF_FFFF_FFFF_FF00;
    fsize = offset + size + WordW'($urandom_range(0, 64));
    case ($urandom_range(0, 9))
      7: begin
        offset = WordW'($urandom_range(0, 15));
        size   = 64'hFFFF_FFFF_FFFF_FFF0;
        fsize  = '1;
      end
      8: begin
        if ($urandom_range(0, 1) == 0) seg_type = $urandom;
        case ($urandom_range(0, 2))
          0: size = '0;
          1: size = {$urandom, $urandom};
          default: ;
        endcase
        offset = {$urandom, $urandom};
        fsize  = {$urandom, $urandom};
      end
      9: seg_type = $urandom;
      default: ;
    endcase
    set_header(seg_type, offset, size, fsize);
  endtask

  // one parse: start, then whole entries, sometimes cut short or overrun
  task automatic random_parse();
    logic [WordW-1:0] n_entries;
    if ($urandom_range(0, 5) == 0) send_item(OP_DATA, 8'($urandom));
    send_item(OP_START, 8'($urandom));
    if (parse_phase != PH_STREAM) begin
      repeat ($urandom_range(0, 2)) send_item(OP_DATA, 8'($urandom));
      return;
    end
    n_entries = hdr_cfg.segment_size >> EntryShift;
    if (n_entries > 8) n_entries = 8;
    if ($urandom_range(0, 3) == 0) n_entries++;
    for (int e = 0; e < n_entries; e++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_entry(pick_tag(), {$urandom, $urandom}, $urandom_range(0, 15));
        return;
      end
      send_entry(pick_tag(), {$urandom, $urandom}, 16);
      if (parse_phase != PH_STREAM && $urandom_range(0, 3) != 0) break;
    end
  endtask

  task automatic test_random_parses(int unsigned target);
    while (fed_items < target) begin
      pick_header();
      repeat ($urandom_range(1, 4)) random_parse();
    end
  endtask

  task automatic check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result leaving the block with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        $display("%0t ns: result with none expected, expected none actual kind %0d tag %h",
                 $time, out_kind_o, out_tag_o);
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("kind", want.kind, out_kind_o);
        check_field("tag", want.tag, out_tag_o);
        check_field("entry_value", want.entry_value, out_entry_value_o);
        check_field("entry_pos", want.entry_pos, out_entry_pos_o);
        check_field("error_code", want.error_code, out_error_code_o);
        check_field("error_offset", want.error_offset, out_error_offset_o);
        check_field("last", want.last, out_last_o);
      end
    end
  end

  // receiver stall: long hold-off on request, else random bursts
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (burst_left != 0) begin
      out_stall_i <= 1'b1;
      burst_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      burst_left = $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_header_checks();
    test_entry_decode();
    test_backpressure();
    test_random_parses(1450);
    // last part runs without idling on either side
    idling_on  = 1'b0;
    burst_left = 0;
    test_random_parses(1650);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/elfdt_pkg.sv
rtl/elfdt_cfg_regs.sv
rtl/elfdt_hdr_check.sv
rtl/elfdt_core.sv
rtl/elfdt_res_fifo.sv
rtl/elf_dynamic_table_parser_unit.sv
sim/tb_elf_dynamic_table_parser_unit.sv
